// ===== rtl/bpc_pkg.sv =====
// Package for the barometric pressure compensation block.
// Holds the coefficient register codes, shared types and scaling constants.
// No dependencies.
package bpc_pkg;

  // Register index codes of the configuration port.
  typedef enum logic [2:0] {
    CfgA0  = 3'd0,
    CfgB1  = 3'd1,
    CfgB2  = 3'd2,
    CfgC12 = 3'd3,
    CfgC11 = 3'd4,
    CfgC22 = 3'd5
  } cfg_idx_e;

  localparam int unsigned CoefW   = 16;
  localparam int unsigned RawW    = 10;
  localparam int unsigned ProdW   = 26;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ValueW  = 22;
  localparam int unsigned CfgIdxW = 3;

  // Polynomial shift amounts.
  localparam int unsigned ShB1   = 14;
  localparam int unsigned ShA11  = 11;
  localparam int unsigned ShB2   = 15;
  localparam int unsigned ShA2   = 16;
  localparam int unsigned ShA0   = 10;
  localparam int unsigned ShY1   = 10;
  localparam int unsigned ShSum  = 13;

  // Output scaling: 65000 * count / 1023 + 50.
  localparam int unsigned ScaleNum = 65 * 100 * 10;
  localparam int unsigned ScaleDen = 1023;
  localparam int          ScaleOfs = 50;

  // floor(2^41 / 1023); the quotient estimate is low by at most one.
  localparam logic [31:0] RecipMult  = 32'd2149582850;
  localparam int unsigned RecipShift = 41;

  typedef struct packed {
    logic signed [CoefW-1:0] a0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] c12;
    logic signed [CoefW-1:0] c11;
    logic signed [CoefW-1:0] c22;
  } coefs_t;

  // One queued sample with its first-order products already formed.
  typedef struct packed {
    logic        [RawW-1:0]  p;
    logic        [RawW-1:0]  t;
    logic signed [ProdW-1:0] pc11;
    logic signed [ProdW-1:0] tc12;
    logic signed [ProdW-1:0] tc22;
  } qentry_t;

endpackage

// ===== rtl/barometric_pressure_compensation_top.sv =====
// Top level of the barometric pressure compensation block.
// Holds the coefficient registers and joins bpc_front, bpc_queue and bpc_back.
// Depends on bpc_pkg.
//
//   Channel | Handshake                  | Signals
//   --------+----------------------------+----------------------------------------
//   config  | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//   sample  | start_i high, busy_o low   | raw_pressure_i, raw_temperature_i
//   result  | result_valid_o, one cycle  | compensated_count_o, pressure_value_o
//
// A new sample is accepted every cycle while busy_o is low; its result passes
// through the front register, the queue write, the registered queue read and
// the nine evaluation stages. Reset clears the coefficients to zero and empties
// the queue and pipeline. The receiver cannot stall; busy_o rises only when the
// queue of QueueDepth entries is close to full.
module barometric_pressure_compensation_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bpc_pkg::CoefW-1:0]           cfg_wdata_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [bpc_pkg::RawW-1:0]            raw_pressure_i,
  input  logic [bpc_pkg::RawW-1:0]            raw_temperature_i,
  output logic                                result_valid_o,
  output logic signed [bpc_pkg::CountW-1:0]   compensated_count_o,
  output logic signed [bpc_pkg::ValueW-1:0]   pressure_value_o
);

  bpc_pkg::coefs_t  coefs_q, coefs_d;
  logic             accept;
  logic             push;
  bpc_pkg::qentry_t entry_in;
  logic             q_valid;
  bpc_pkg::qentry_t entry_out;
  logic             almost_full;

  always_comb begin
    coefs_d = coefs_q;
    if (cfg_we_i) begin
      case (bpc_pkg::cfg_idx_e'(cfg_idx_i))
        bpc_pkg::CfgA0:  coefs_d.a0  = cfg_wdata_i;
        bpc_pkg::CfgB1:  coefs_d.b1  = cfg_wdata_i;
        bpc_pkg::CfgB2:  coefs_d.b2  = cfg_wdata_i;
        bpc_pkg::CfgC12: coefs_d.c12 = cfg_wdata_i;
        bpc_pkg::CfgC11: coefs_d.c11 = cfg_wdata_i;
        bpc_pkg::CfgC22: coefs_d.c22 = cfg_wdata_i;
        default:         coefs_d     = coefs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= '0;
    end else begin
      coefs_q <= coefs_d;
    end
  end

  assign busy_o = almost_full;
  assign accept = start_i && !busy_o;

  bpc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .coefs_i           (coefs_q),
    .push_o            (push),
    .entry_o           (entry_in)
  );

  bpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .data_i        (entry_in),
    .almost_full_o (almost_full),
    .valid_o       (q_valid),
    .data_o        (entry_out)
  );

  bpc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (q_valid),
    .entry_i             (entry_out),
    .coefs_i             (coefs_q),
    .result_valid_o      (result_valid_o),
    .compensated_count_o (compensated_count_o),
    .pressure_value_o    (pressure_value_o)
  );

endmodule

// ===== rtl/bpc_front.sv =====
// Front end of the compensation block: registers accepted samples and forms
// the first-order products before they enter the queue.
// Depends on bpc_pkg.
module bpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [bpc_pkg::RawW-1:0]        raw_pressure_i,
  input  logic [bpc_pkg::RawW-1:0]        raw_temperature_i,
  input  bpc_pkg::coefs_t                 coefs_i,
  output logic                            push_o,
  output bpc_pkg::qentry_t                entry_o
);

  logic                       vld_q;
  logic [bpc_pkg::RawW-1:0]   p_q;
  logic [bpc_pkg::RawW-1:0]   t_q;
  logic signed [31:0]         p_ext;
  logic signed [31:0]         t_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p_q <= raw_pressure_i;
      t_q <= raw_temperature_i;
    end
  end

  assign p_ext = $signed({22'd0, p_q});
  assign t_ext = $signed({22'd0, t_q});

  assign push_o       = vld_q;
  assign entry_o.p    = p_q;
  assign entry_o.t    = t_q;
  assign entry_o.pc11 = bpc_pkg::ProdW'(32'($signed(coefs_i.c11)) * p_ext);
  assign entry_o.tc12 = bpc_pkg::ProdW'(32'($signed(coefs_i.c12)) * t_ext);
  assign entry_o.tc22 = bpc_pkg::ProdW'(32'($signed(coefs_i.c22)) * t_ext);

endmodule

// ===== rtl/bpc_queue.sv =====
// Short queue between the front end and the evaluation pipeline.
// Memory with registered read; drains one entry per cycle. Depends on bpc_pkg.
module bpc_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bpc_pkg::qentry_t data_i,
  output logic             almost_full_o,
  output logic             valid_o,
  output bpc_pkg::qentry_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bpc_pkg::qentry_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             vld_q;
  bpc_pkg::qentry_t out_q;
  logic             pop;

  // The pipeline behind never stalls, so any stored entry is taken at once.
  assign pop = (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      vld_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      vld_q    <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= mem[rd_ptr_q];
    end
  end

  // One slot of margin covers the sample held in the front register.
  assign almost_full_o = (cnt_q >= CntW'(Depth - 1));
  assign valid_o       = vld_q;
  assign data_o        = out_q;

endmodule

// ===== rtl/bpc_back.sv =====
// Evaluation pipeline of the compensation block: polynomial, output scaling
// and division by 1023 through a reciprocal with one correction step.
// Depends on bpc_pkg.
module bpc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  bpc_pkg::qentry_t                     entry_i,
  input  bpc_pkg::coefs_t                      coefs_i,
  output logic                                 result_valid_o,
  output logic signed [bpc_pkg::CountW-1:0]    compensated_count_o,
  output logic signed [bpc_pkg::ValueW-1:0]    pressure_value_o
);

  localparam int unsigned Stages = 9;

  logic [Stages-1:0] vld_q;

  // Stage 2: a11 and a2.
  logic signed [31:0]       s2_sum11, s2_sum2;
  logic signed [17:0]       a11_q;
  logic signed [16:0]       a2_s2_q;
  logic signed [bpc_pkg::ProdW-1:0] tc12_q;
  logic [bpc_pkg::RawW-1:0] p_s2_q, t_s2_q;
  // Stage 3: a1.
  logic signed [31:0]       s3_sum1;
  logic signed [17:0]       a1_q;
  logic signed [16:0]       a2_s3_q;
  logic [bpc_pkg::RawW-1:0] p_s3_q, t_s3_q;
  // Stage 4: second products.
  logic signed [31:0]       a1p_q, a2t_q;
  // Stage 5: y1.
  logic signed [31:0]       s5_sumy;
  logic signed [18:0]       y1_q;
  logic signed [31:0]       a2t_s5_q;
  // Stage 6: count, sign and magnitude.
  logic signed [31:0]       s6_sum;
  logic signed [bpc_pkg::CountW-1:0] cnt_d;
  logic signed [bpc_pkg::CountW-1:0] cnt6_q, cnt7_q, cnt8_q, cnt9_q, cnt10_q;
  logic [bpc_pkg::CountW-1:0]        mag_q;
  logic                              neg6_q, neg7_q, neg8_q, neg9_q;
  // Stage 7: scaled magnitude.
  logic [30:0]              m7_q, m8_q;
  // Stage 8: reciprocal product.
  logic [62:0]              prod_q;
  // Stage 9: quotient estimate and remainder.
  logic [20:0]              q0;
  logic [20:0]              q0_q;
  logic [10:0]              rem_q;
  // Stage 10: result.
  logic signed [bpc_pkg::ValueW-1:0] q_fix;
  logic signed [bpc_pkg::ValueW-1:0] value_d;
  logic signed [bpc_pkg::ValueW-1:0] value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  always_comb begin
    s2_sum11 = (32'($signed(coefs_i.b1)) <<< bpc_pkg::ShB1) + 32'($signed(entry_i.pc11));
    s2_sum2  = (32'($signed(coefs_i.b2)) <<< bpc_pkg::ShB2)
             + (32'($signed(entry_i.tc22)) >>> 1);
    s3_sum1  = (32'(a11_q) <<< bpc_pkg::ShA11) + 32'(tc12_q);
    s5_sumy  = (32'($signed(coefs_i.a0)) <<< bpc_pkg::ShA0) + a1p_q;
    s6_sum   = (32'(y1_q) <<< bpc_pkg::ShY1) + a2t_s5_q;
    cnt_d    = s6_sum[bpc_pkg::ShSum +: bpc_pkg::CountW];
    q0       = prod_q[bpc_pkg::RecipShift +: 21];
    q_fix    = bpc_pkg::ValueW'(q0_q)
             + bpc_pkg::ValueW'(rem_q >= 11'(bpc_pkg::ScaleDen));
    value_d  = (neg9_q ? -q_fix : q_fix) + bpc_pkg::ValueW'(bpc_pkg::ScaleOfs);
  end

  always_ff @(posedge clk_i) begin
    // Stage 2
    a11_q   <= 18'(s2_sum11 >>> bpc_pkg::ShB1);
    a2_s2_q <= 17'(s2_sum2 >>> bpc_pkg::ShA2);
    tc12_q  <= entry_i.tc12;
    p_s2_q  <= entry_i.p;
    t_s2_q  <= entry_i.t;
    // Stage 3
    a1_q    <= 18'(s3_sum1 >>> bpc_pkg::ShA11);
    a2_s3_q <= a2_s2_q;
    p_s3_q  <= p_s2_q;
    t_s3_q  <= t_s2_q;
    // Stage 4
    a1p_q   <= 32'(a1_q) * $signed({22'd0, p_s3_q});
    a2t_q   <= 32'(a2_s3_q) * $signed({22'd0, t_s3_q});
    // Stage 5
    y1_q     <= 19'(s5_sumy >>> bpc_pkg::ShY1);
    a2t_s5_q <= a2t_q;
    // Stage 6
    cnt6_q  <= cnt_d;
    neg6_q  <= cnt_d[bpc_pkg::CountW-1];
    mag_q   <= cnt_d[bpc_pkg::CountW-1] ? 16'(-cnt_d) : 16'(cnt_d);
    // Stage 7
    m7_q    <= 31'(32'(mag_q) * 32'(bpc_pkg::ScaleNum));
    cnt7_q  <= cnt6_q;
    neg7_q  <= neg6_q;
    // Stage 8
    prod_q  <= 63'(m7_q) * 63'(bpc_pkg::RecipMult);
    m8_q    <= m7_q;
    cnt8_q  <= cnt7_q;
    neg8_q  <= neg7_q;
    // Stage 9: remainder m - 1023*q0 lies below twice the divisor.
    q0_q    <= q0;
    rem_q   <= 11'(32'(m8_q) - (32'(q0) << 10) + 32'(q0));
    cnt9_q  <= cnt8_q;
    neg9_q  <= neg8_q;
    // Stage 10
    value_q <= value_d;
    cnt10_q <= cnt9_q;
  end

  assign result_valid_o      = vld_q[Stages-1];
  assign compensated_count_o = cnt10_q;
  assign pressure_value_o    = value_q;

endmodule

// ===== rtl/bpc_checker.sv =====
// Port-level checker for the compensation block, bound to the top level.
// Depends on bpc_pkg for field widths.
module bpc_checker #(
  parameter int unsigned Latency = 12
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              result_valid_o,
  input logic [bpc_pkg::CountW-1:0]        compensated_count_o,
  input logic [bpc_pkg::ValueW-1:0]        pressure_value_o
);

  localparam int unsigned AgeW = $clog2(Latency + 1);

  logic [AgeW-1:0] age_q;
  logic            settled;
  logic            accepted;

  // Cycles since reset, so that transactions cut off by a reset are not expected.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else if (age_q != AgeW'(Latency)) begin
      age_q <= age_q + 1'b1;
    end
  end

  assign settled  = (age_q == AgeW'(Latency));
  assign accepted = start_i && !busy_o;

  // Every accepted transaction yields exactly one result, and every result strobe follows an accepted one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled |-> (result_valid_o == $past(accepted, Latency)))
    else $error("result strobe does not follow an accepted transaction");

  // A zero count scales to the offset alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (compensated_count_o == '0)) |->
      (pressure_value_o == bpc_pkg::ValueW'(bpc_pkg::ScaleOfs)))
    else $error("zero count does not give the offset value");

  // A non-negative count never gives a negative pressure value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !compensated_count_o[bpc_pkg::CountW-1]) |->
      !pressure_value_o[bpc_pkg::ValueW-1])
    else $error("pressure value sign disagrees with count");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start_i             (start_i),
  .busy_o              (busy_o),
  .result_valid_o      (result_valid_o),
  .compensated_count_o (compensated_count_o),
  .pressure_value_o    (pressure_value_o)
);
